@@ rtl/ard_pkg.sv @@
package ard_pkg;

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN    = 8'd1;

	localparam logic [31:0] MAX_FRAME_LEN_RST = 32'd65536;
	localparam logic [31:0] CRC_POLY = 32'h82F63B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam int PREFIX_BYTES = 12;
	localparam int LEN_BYTES    = 4;
	localparam int TIME_BYTES   = PREFIX_BYTES - LEN_BYTES;
	localparam int FCS_BYTES    = 4;
	localparam int IDX_W        = $clog2(TIME_BYTES);

	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);
	localparam int RQ_CW    = RQ_AW + 1;

	localparam logic KIND_FRAME  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic [2:0] {
		PH_TIME,
		PH_LEN,
		PH_FRAME,
		PH_CRC,
		PH_HALT
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_CRC_BAD,
		ST_TOO_LARGE,
		ST_TRUNC
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  frame_byte;
		logic [63:0] capture_time;
		logic [31:0] frame_length;
		logic [63:0] record_offset;
		status_t     status;
		logic        last;
	} result_t;

	// p1 only ever set together with p0
	typedef struct packed {
		logic    p0;
		logic    p1;
		result_t r0;
		result_t r1;
	} push_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/ard_if.sv @@
interface ard_in_if;
	import ard_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface ard_out_if;
	import ard_pkg::*;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  frame_byte;
	logic [63:0] capture_time;
	logic [31:0] frame_length;
	logic [63:0] record_offset;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, output kind, output frame_byte, output capture_time,
		output frame_length, output record_offset, output status, output last, input ready);
	modport sink (input valid, input kind, input frame_byte, input capture_time,
		input frame_length, input record_offset, input status, input last, output ready);
endinterface

interface ard_cfg_if;
	import ard_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/ard_in_reg.sv @@
module ard_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	ard_in_if.sink         rec_in,
	input  logic           take,
	output logic           vld_s1,
	output ard_pkg::item_t item_s1
);
	import ard_pkg::*;

	assign rec_in.ready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rec_in.ready) begin
			vld_s1 <= rec_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_in.ready && rec_in.valid) begin
			item_s1.data_byte     <= rec_in.data_byte;
			item_s1.end_of_stream <= rec_in.end_of_stream;
		end
	end

endmodule

@@ rtl/ard_engine.sv @@
module ard_engine #(
	parameter int LENGTH_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	ard_cfg_if.sink        cfg,
	input  logic           take,
	input  ard_pkg::item_t item_s1,
	output ard_pkg::push_t push
);
	import ard_pkg::*;

	localparam logic [31:0] LEN_CAP = 32'((64'd1 << LENGTH_BITS) - 64'd1);

	logic [31:0]            max_len_q;
	logic                   big_q;
	phase_t                 phase_q, phase_n;
	logic [IDX_W-1:0]       idx_q, idx_n;
	logic [LENGTH_BITS-1:0] fcnt_q, fcnt_n;
	logic [63:0]            time_q, time_n;
	logic [31:0]            len_q, len_n;
	logic [31:0]            crc_q, crc_n;
	logic [31:0]            crx_q, crx_n;
	logic [63:0]            offset_q, offset_n;
	logic [63:0]            start_q, start_n;

	logic        new_rec;
	logic [31:0] crc_in;
	logic [31:0] crc_upd;
	logic [7:0]  b;
	logic        eos;
	logic        halt;
	logic        done;
	logic        emit_byte;
	logic        emit_rep;
	status_t     rep_st;
	result_t     byte_res;
	result_t     rep_res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_FRAME_LEN_RST;
			big_q     <= 1'b0;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_MAX_FRAME_LEN) begin
				max_len_q <= cfg.data;
			end
			if (cfg.index == CFG_BIG_ENDIAN) begin
				big_q <= cfg.data[0];
			end
		end
	end

	assign b       = item_s1.data_byte;
	assign new_rec = (phase_q == PH_TIME) && (idx_q == '0);
	assign crc_in  = new_rec ? CRC_INIT : crc_q;
	assign crc_upd = crc_byte(crc_in, b);

	always_comb begin
		logic [63:0] tv;
		logic [31:0] lv;
		logic [31:0] rv;
		tv        = new_rec ? 64'd0 : time_q;
		lv        = new_rec ? 32'd0 : len_q;
		rv        = new_rec ? 32'd0 : crx_q;
		phase_n   = phase_q;
		idx_n     = idx_q;
		fcnt_n    = fcnt_q;
		time_n    = tv;
		len_n     = lv;
		crc_n     = crc_in;
		crx_n     = rv;
		start_n   = new_rec ? offset_q : start_q;
		offset_n  = offset_q + 64'd1;
		eos       = item_s1.end_of_stream;
		halt      = 1'b0;
		done      = 1'b0;
		emit_byte = 1'b0;
		emit_rep  = 1'b0;
		rep_st    = ST_OK;

		case (phase_q)
			PH_TIME: begin
				crc_n  = crc_upd;
				time_n = big_q ? {tv[55:0], b} : (tv | ({56'd0, b} << {idx_q, 3'b000}));
				if (idx_q == IDX_W'(TIME_BYTES - 1)) begin
					phase_n = PH_LEN;
					idx_n   = '0;
				end else begin
					idx_n = idx_q + 1'b1;
				end
			end
			PH_LEN: begin
				crc_n = crc_upd;
				len_n = big_q ? {lv[23:0], b} : (lv | ({24'd0, b} << {idx_q[1:0], 3'b000}));
				if (idx_q == IDX_W'(LEN_BYTES - 1)) begin
					idx_n = '0;
					if (len_n > max_len_q || len_n > LEN_CAP) begin
						emit_rep = 1'b1;
						rep_st   = ST_TOO_LARGE;
						halt     = 1'b1;
						eos      = 1'b0;
					end else begin
						phase_n = (len_n == 32'd0) ? PH_CRC : PH_FRAME;
						fcnt_n  = '0;
					end
				end else begin
					idx_n = idx_q + 1'b1;
				end
			end
			PH_FRAME: begin
				crc_n     = crc_upd;
				emit_byte = 1'b1;
				if (fcnt_q == lv[LENGTH_BITS-1:0] - 1'b1) begin
					fcnt_n  = '0;
					idx_n   = '0;
					phase_n = PH_CRC;
				end else begin
					fcnt_n = fcnt_q + 1'b1;
				end
			end
			PH_CRC: begin
				crx_n = big_q ? {rv[23:0], b} : (rv | ({24'd0, b} << {idx_q[1:0], 3'b000}));
				if (idx_q == IDX_W'(FCS_BYTES - 1)) begin
					emit_rep = 1'b1;
					rep_st   = ((~crc_in) == crx_n) ? ST_OK : ST_CRC_BAD;
					idx_n    = '0;
					phase_n  = PH_TIME;
					done     = 1'b1;
					halt     = (rep_st != ST_OK);
				end else begin
					idx_n = idx_q + 1'b1;
				end
			end
			default: begin
				// halted: inputs are dropped until reset
				offset_n = offset_q;
				eos      = 1'b0;
			end
		endcase

		if (eos && !halt) begin
			if (done || (phase_n == PH_TIME && idx_n == '0)) begin
				offset_n = 64'd0;
			end else begin
				emit_rep = 1'b1;
				rep_st   = ST_TRUNC;
				halt     = 1'b1;
			end
		end

		if (halt) begin
			phase_n = PH_HALT;
		end
	end

	always_comb begin
		byte_res               = '0;
		byte_res.kind          = KIND_FRAME;
		byte_res.frame_byte    = b;
		byte_res.status        = ST_OK;
		byte_res.last          = !emit_rep;
		rep_res                = '0;
		rep_res.kind           = KIND_REPORT;
		rep_res.capture_time   = time_n;
		rep_res.frame_length   = len_n;
		rep_res.record_offset  = start_n;
		rep_res.status         = rep_st;
		rep_res.last           = 1'b1;
		push.p0 = take && (emit_byte || emit_rep);
		push.p1 = take && emit_byte && emit_rep;
		push.r0 = emit_byte ? byte_res : rep_res;
		push.r1 = rep_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TIME;
			idx_q    <= '0;
			fcnt_q   <= '0;
			time_q   <= '0;
			len_q    <= '0;
			crc_q    <= CRC_INIT;
			crx_q    <= '0;
			offset_q <= '0;
			start_q  <= '0;
		end else if (take) begin
			phase_q  <= phase_n;
			idx_q    <= idx_n;
			fcnt_q   <= fcnt_n;
			time_q   <= time_n;
			len_q    <= len_n;
			crc_q    <= crc_n;
			crx_q    <= crx_n;
			offset_q <= offset_n;
			start_q  <= start_n;
		end
	end

endmodule

@@ rtl/ard_res_fifo.sv @@
module ard_res_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  ard_pkg::push_t push,
	output logic           room,
	ard_out_if.source      rec_out
);
	import ard_pkg::*;

	result_t          mem [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_q;
	logic [RQ_AW-1:0] rd_q;
	logic [RQ_CW-1:0] cnt_q;
	logic             pop;
	logic [RQ_CW-1:0] n_push;
	result_t          head;

	// an item may yield two results, so keep two slots free
	assign room   = (cnt_q <= RQ_CW'(RQ_DEPTH - 2));
	assign pop    = rec_out.valid && rec_out.ready;
	assign n_push = RQ_CW'(push.p0) + RQ_CW'(push.p1);
	assign head   = mem[rd_q];

	assign rec_out.valid         = (cnt_q != '0);
	assign rec_out.kind          = head.kind;
	assign rec_out.frame_byte    = head.frame_byte;
	assign rec_out.capture_time  = head.capture_time;
	assign rec_out.frame_length  = head.frame_length;
	assign rec_out.record_offset = head.record_offset;
	assign rec_out.status        = head.status;
	assign rec_out.last          = head.last;

	always_ff @(posedge clk) begin
		if (push.p0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.p1) begin
			mem[wr_q + 1'b1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[RQ_AW-1:0];
			rd_q  <= rd_q + RQ_AW'(pop);
			cnt_q <= cnt_q + n_push - RQ_CW'(pop);
		end
	end

endmodule

@@ rtl/archive_record_deframer_core.sv @@
// Record deframer for capture archives: takes one byte per request, and with a ready sink
// it accepts a byte every cycle. A byte is held in the input register, then the
// parse/CRC-32C step writes its results into a four-entry result queue, which the sink
// reads. Frame bytes come out as they arrive; a status report follows the last CRC
// byte, an oversized length or a stream end inside a record. After any error report the
// block drops all further bytes until reset. Configuration writes are taken at any time
// but must only be issued while the block is idle.
module archive_record_deframer_core #(
	parameter int LENGTH_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ard_in_if.sink     rec_in,
	ard_out_if.source  rec_out,
	ard_cfg_if.sink    cfg
);
	import ard_pkg::*;

	logic  vld_s1;
	item_t item_s1;
	logic  room;
	logic  take;
	push_t push;

	assign take = vld_s1 && room;

	ard_in_reg u_in_reg (
		.clk     (clk),
		.arst_n  (arst_n),
		.rec_in  (rec_in),
		.take    (take),
		.vld_s1  (vld_s1),
		.item_s1 (item_s1)
	);

	ard_engine #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.take    (take),
		.item_s1 (item_s1),
		.push    (push)
	);

	ard_res_fifo u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.rec_out (rec_out)
	);

endmodule
